### sv/bmpd_pkg.sv
// ----------------------------------------------------------------------------
// bmpd_pkg
// Shared types and constants for the BMP to RGBA decoder.
// ----------------------------------------------------------------------------
package bmpd_pkg;

  // Decode phase of the front end.
  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_SKIP   = 3'd1,
    PH_PIXELS = 3'd2,
    PH_PAD    = 3'd3,
    PH_DONE   = 3'd4,
    PH_ERROR  = 3'd5
  } phase_t;

  // Result status codes.
  localparam logic [2:0] ST_PIXEL    = 3'd0;
  localparam logic [2:0] ST_SIG      = 3'd1;
  localparam logic [2:0] ST_PLANES   = 3'd2;
  localparam logic [2:0] ST_BPP      = 3'd3;
  localparam logic [2:0] ST_COMPRESS = 3'd4;
  localparam logic [2:0] ST_DIM      = 3'd5;
  localparam logic [2:0] ST_PALETTE  = 3'd6;
  localparam logic [2:0] ST_TRUNC    = 3'd7;

  // Header layout.
  localparam logic [31:0] HDR_LEN    = 32'd50;
  localparam logic [5:0]  POS_OFFSET = 6'd10;
  localparam logic [5:0]  POS_WIDTH  = 6'd18;
  localparam logic [5:0]  POS_HEIGHT = 6'd22;
  localparam logic [5:0]  POS_PLANES = 6'd26;
  localparam logic [5:0]  POS_BPP    = 6'd28;
  localparam logic [5:0]  POS_COMPR  = 6'd30;
  localparam logic [5:0]  POS_PALCNT = 6'd46;

  localparam int QDEPTH = 4;

  // One result as produced by the front end; palette pixels are resolved later.
  typedef struct packed {
    logic       pal;
    logic       hit;
    logic [7:0] idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
    logic [2:0] status;
  } result_t;

  // Queue entry: the results caused by one input byte.
  typedef struct packed {
    logic    two;
    result_t res0;
    result_t res1;
  } entry_t;

endpackage

### sv/bmpd_ram.sv
// ----------------------------------------------------------------------------
// bmpd_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bmpd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/bmpd_queue.sv
// ----------------------------------------------------------------------------
// bmpd_queue
// Short queue of per-byte result entries between front and back end.
// ----------------------------------------------------------------------------
module bmpd_queue import bmpd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  output logic   empty,
  input  logic   pop,
  output entry_t head
);

  localparam int AW = $clog2(QDEPTH);

  entry_t          slots [QDEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     count;

  assign full  = (count == (AW+1)'(QDEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### sv/bmpd_front.sv
// ----------------------------------------------------------------------------
// bmpd_front
// Byte parser: checks the header, captures the palette and turns pixel
// bytes into result entries for the back end.
// ----------------------------------------------------------------------------
module bmpd_front import bmpd_pkg::*; #(
  parameter int MAX_DIM       = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_data,
  input  logic                             in_last,
  output logic                             push,
  output entry_t                           push_entry,
  input  logic                             q_full,
  input  logic                             q_empty,
  output logic                             pal_we,
  output logic [$clog2(PALETTE_DEPTH)-1:0] pal_waddr,
  output logic [23:0]                      pal_wdata
);

  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int CW = $clog2(PALETTE_DEPTH + 1);
  localparam int IW = $clog2(PALETTE_DEPTH);

  // State registers.
  phase_t         phase, phase_next;
  logic [31:0]    pos, pos_next;
  logic [31:0]    offset, offset_next;
  logic [31:0]    base, base_next;
  logic [DW-1:0]  width, width_next;
  logic [DW-1:0]  height, height_next;
  logic [5:0]     bpp, bpp_next;
  logic [CW-1:0]  pcount, pcount_next;
  logic [DW-1:0]  col, col_next;
  logic [DW-1:0]  row, row_next;
  logic [23:0]    pend, pend_next;
  logic [1:0]     bip, bip_next;
  logic [1:0]     rbp, rbp_next;

  // Per-byte working signals.
  logic           accept;
  logic           in_skip_range;
  logic [31:0]    rel;
  logic           wr_slot;
  logic [5:0]     p;
  logic           fld;
  logic [5:0]     first;
  logic [1:0]     lenm1;
  logic [1:0]     k;
  logic [31:0]    word;
  logic           fdone;
  logic [2:0]     err;
  logic [1:0]     n;
  logic           row_end;
  logic [DW:0]    c1, c2, r1;
  result_t        res0, res1;

  // Palette capture window: byte offset into the palette and write slot.
  assign in_skip_range = (bpp <= 6'd8) && (pos >= base) && (pos < offset);
  assign rel           = pos - base;
  assign wr_slot       = (phase == PH_SKIP) && in_skip_range && (rel[1:0] == 2'd2);

  // Hold off a palette write while older pixels may still read the palette.
  assign in_ready = !q_full && !(wr_slot && !q_empty);
  assign accept   = in_valid && in_ready;

  assign push             = accept && (n != 2'd0);
  assign push_entry.two   = (n == 2'd2);
  assign push_entry.res0  = res0;
  assign push_entry.res1  = res1;

  assign pal_we    = accept && wr_slot;
  assign pal_waddr = rel[IW+1:2];
  assign pal_wdata = {in_data, pend[15:0]};

  // Header field decode: which little-endian field this byte belongs to.
  always_comb begin
    p     = pos[5:0];
    fld   = 1'b0;
    first = '0;
    lenm1 = '0;
    if (pos < HDR_LEN) begin
      if (p inside {[6'd10:6'd13]}) begin
        fld = 1'b1; first = POS_OFFSET; lenm1 = 2'd3;
      end else if (p inside {[6'd18:6'd21]}) begin
        fld = 1'b1; first = POS_WIDTH; lenm1 = 2'd3;
      end else if (p inside {[6'd22:6'd25]}) begin
        fld = 1'b1; first = POS_HEIGHT; lenm1 = 2'd3;
      end else if (p inside {[6'd26:6'd27]}) begin
        fld = 1'b1; first = POS_PLANES; lenm1 = 2'd1;
      end else if (p inside {[6'd28:6'd29]}) begin
        fld = 1'b1; first = POS_BPP; lenm1 = 2'd1;
      end else if (p inside {[6'd30:6'd33]}) begin
        fld = 1'b1; first = POS_COMPR; lenm1 = 2'd3;
      end else if (p inside {[6'd46:6'd49]}) begin
        fld = 1'b1; first = POS_PALCNT; lenm1 = 2'd3;
      end
    end
    k     = 2'(p - first);
    word  = (k == 2'd0) ? 32'(in_data)
                        : (32'(pend) | (32'(in_data) << {k, 3'b000}));
    fdone = fld && (k == lenm1);
  end

  // Next-state and result logic for one byte.
  always_comb begin
    phase_next  = phase;
    pos_next    = pos;
    offset_next = offset;
    base_next   = base;
    width_next  = width;
    height_next = height;
    bpp_next    = bpp;
    pcount_next = pcount;
    col_next    = col;
    row_next    = row;
    pend_next   = pend;
    bip_next    = bip;
    rbp_next    = rbp;
    err         = '0;
    n           = '0;
    row_end     = 1'b0;
    res0        = '0;
    res1        = '0;
    c1          = {1'b0, col} + 1'b1;
    c2          = c1 + 1'b1;
    r1          = {1'b0, row} + 1'b1;

    case (phase)
      PH_HEADER: begin
        if (pos == 32'd0 && in_data != 8'h42) begin
          err = ST_SIG;
        end
        if (pos == 32'd1 && in_data != 8'h4D) begin
          err = ST_SIG;
        end
        if (fld && !fdone) begin
          pend_next = word[23:0];
        end
        if (fdone) begin
          case (first)
            POS_OFFSET: offset_next = word;
            POS_WIDTH: begin
              if (word == 32'd0 || word > 32'(MAX_DIM)) err = ST_DIM;
              else width_next = DW'(word);
            end
            POS_HEIGHT: begin
              if (word == 32'd0 || word > 32'(MAX_DIM)) err = ST_DIM;
              else height_next = DW'(word);
            end
            POS_PLANES: begin
              if (word != 32'd1) err = ST_PLANES;
            end
            POS_BPP: begin
              if (word != 32'd4 && word != 32'd8 && word != 32'd24 && word != 32'd32)
                err = ST_BPP;
              else bpp_next = word[5:0];
            end
            POS_COMPR: begin
              if (word != 32'd0 && (word != 32'd3 || bpp != 6'd32)) err = ST_COMPRESS;
            end
            POS_PALCNT: begin
              if (word > 32'(PALETTE_DEPTH)) begin
                err = ST_PALETTE;
              end else if (bpp <= 6'd8 &&
                           (word == 32'd0 || offset < HDR_LEN + {word[29:0], 2'b00})) begin
                err = ST_PALETTE;
              end else begin
                pcount_next = CW'(word);
                base_next   = offset - {word[29:0], 2'b00};
                phase_next  = (offset <= HDR_LEN) ? PH_PIXELS : PH_SKIP;
              end
            end
            default: ;
          endcase
        end
      end

      PH_SKIP: begin
        if (in_skip_range) begin
          case (rel[1:0])
            2'd0:    pend_next[7:0]  = in_data;
            2'd1:    pend_next[15:8] = in_data;
            default: ;
          endcase
        end
        if ({1'b0, pos} + 33'd1 >= {1'b0, offset}) begin
          phase_next = PH_PIXELS;
        end
      end

      PH_PIXELS: begin
        if (bpp == 6'd4 || bpp == 6'd8) begin
          // Palette pixel(s): first index from the high nibble or whole byte.
          res0.pal    = 1'b1;
          res0.alpha  = 8'hFF;
          res0.status = ST_PIXEL;
          res0.idx    = (bpp == 6'd4) ? {4'h0, in_data[7:4]} : in_data;
          res0.hit    = 32'(res0.idx) < 32'(pcount);
          n           = 2'd1;
          if (c1 >= {1'b0, width}) begin
            row_end  = 1'b1;
            col_next = '0;
            row_next = DW'(r1);
            if (r1 >= {1'b0, height}) begin
              res0.last  = 1'b1;
              phase_next = PH_DONE;
            end
          end else if (bpp == 6'd4) begin
            res1.pal    = 1'b1;
            res1.alpha  = 8'hFF;
            res1.status = ST_PIXEL;
            res1.idx    = {4'h0, in_data[3:0]};
            res1.hit    = 32'(res1.idx) < 32'(pcount);
            n           = 2'd2;
            if (c2 >= {1'b0, width}) begin
              row_end  = 1'b1;
              col_next = '0;
              row_next = DW'(r1);
              if (r1 >= {1'b0, height}) begin
                res1.last  = 1'b1;
                phase_next = PH_DONE;
              end
            end else begin
              col_next = DW'(c2);
            end
          end else begin
            col_next = DW'(c1);
          end
        end else begin
          // Direct color: collect B, G (, R) and emit on the final byte.
          if (bip >= ((bpp == 6'd32) ? 2'd3 : 2'd2)) begin
            res0.status = ST_PIXEL;
            if (bpp == 6'd32) begin
              res0.red   = pend[23:16];
              res0.green = pend[15:8];
              res0.blue  = pend[7:0];
              res0.alpha = in_data;
            end else begin
              res0.red   = in_data;
              res0.green = pend[15:8];
              res0.blue  = pend[7:0];
              res0.alpha = 8'hFF;
            end
            n         = 2'd1;
            bip_next  = '0;
            pend_next = '0;
            if (c1 >= {1'b0, width}) begin
              row_end  = 1'b1;
              col_next = '0;
              row_next = DW'(r1);
              if (r1 >= {1'b0, height}) begin
                res0.last  = 1'b1;
                phase_next = PH_DONE;
              end
            end else begin
              col_next = DW'(c1);
            end
          end else begin
            case (bip)
              2'd0:    pend_next[7:0]   = in_data;
              2'd1:    pend_next[15:8]  = in_data;
              default: pend_next[23:16] = in_data;
            endcase
            bip_next = bip + 2'd1;
          end
        end
        rbp_next = rbp + 2'd1;
        if (row_end && phase_next == PH_PIXELS && rbp_next != 2'd0) begin
          phase_next = PH_PAD;
        end
      end

      PH_PAD: begin
        rbp_next = rbp + 2'd1;
        if (rbp_next == 2'd0) begin
          phase_next = PH_PIXELS;
        end
      end

      default: ;
    endcase

    // A header error replaces everything else from this byte.
    if (err != 3'd0) begin
      res0        = '0;
      res0.last   = 1'b1;
      res0.status = err;
      n           = 2'd1;
      phase_next  = PH_ERROR;
    end

    if (pos != 32'hFFFF_FFFF) begin
      pos_next = pos + 32'd1;
    end

    // End of file: report truncation if needed and re-arm.
    if (in_last) begin
      if (phase_next != PH_DONE && phase_next != PH_ERROR) begin
        res0        = '0;
        res0.last   = 1'b1;
        res0.status = ST_TRUNC;
        n           = 2'd1;
      end
      phase_next  = PH_HEADER;
      pos_next    = '0;
      offset_next = '0;
      base_next   = '0;
      width_next  = '0;
      height_next = '0;
      bpp_next    = '0;
      pcount_next = '0;
      col_next    = '0;
      row_next    = '0;
      pend_next   = '0;
      bip_next    = '0;
      rbp_next    = '0;
    end
  end

  // State update on each accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_HEADER;
      pos    <= '0;
      offset <= '0;
      base   <= '0;
      width  <= '0;
      height <= '0;
      bpp    <= '0;
      pcount <= '0;
      col    <= '0;
      row    <= '0;
      pend   <= '0;
      bip    <= '0;
      rbp    <= '0;
    end else if (accept) begin
      phase  <= phase_next;
      pos    <= pos_next;
      offset <= offset_next;
      base   <= base_next;
      width  <= width_next;
      height <= height_next;
      bpp    <= bpp_next;
      pcount <= pcount_next;
      col    <= col_next;
      row    <= row_next;
      pend   <= pend_next;
      bip    <= bip_next;
      rbp    <= rbp_next;
    end
  end

endmodule

### sv/bmpd_back.sv
// ----------------------------------------------------------------------------
// bmpd_back
// Result stage: splits queue entries into single items, looks palette
// indices up in the palette RAM and holds the outgoing item.
// ----------------------------------------------------------------------------
module bmpd_back import bmpd_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  entry_t                           head,
  input  logic                             q_empty,
  output logic                             pop,
  output logic                             pal_re,
  output logic [$clog2(PALETTE_DEPTH)-1:0] pal_raddr,
  input  logic [23:0]                      pal_rdata,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [31:0]                      out_data,
  output logic                             out_last,
  output logic [2:0]                       out_status
);

  localparam int IW = $clog2(PALETTE_DEPTH);

  logic    sub;
  logic    load;
  logic    held_valid;
  result_t cur;
  result_t held;

  // Pick the next item from the head entry.
  assign cur       = sub ? head.res1 : head.res0;
  assign load      = !q_empty && (!held_valid || out_ready);
  assign pop       = load && (sub || !head.two);
  assign pal_re    = load;
  assign pal_raddr = cur.idx[IW-1:0];

  // Item sequencing and the output holding register.
  always_ff @(posedge clk) begin
    if (rst) begin
      sub        <= 1'b0;
      held_valid <= 1'b0;
    end else begin
      if (load) begin
        sub <= !pop;
      end
      if (load) begin
        held_valid <= 1'b1;
      end else if (out_ready) begin
        held_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= cur;
    end
  end

  // Palette pixels take their color from the RAM read issued at load.
  always_comb begin
    out_valid  = held_valid;
    out_last   = held.last;
    out_status = held.status;
    if (held.pal) begin
      out_data = held.hit ? {held.alpha, pal_rdata[7:0], pal_rdata[15:8], pal_rdata[23:16]}
                          : {held.alpha, 24'h000000};
    end else begin
      out_data = {held.alpha, held.blue, held.green, held.red};
    end
  end

endmodule

### sv/bmp_to_rgba_decoder_unit.sv
// ----------------------------------------------------------------------------
// bmp_to_rgba_decoder_unit
// Streaming BMP file decoder producing RGBA8 pixels or an error status.
// ----------------------------------------------------------------------------
// The block takes one file byte per cycle on the input stream while the
// queue has room. Header checking, palette capture and pixel assembly are
// done on each byte as it is accepted. Each output item is one pixel or one
// error status. It passes through the result queue and then a registered
// output stage, which gives one item per cycle while the receiver is ready.
// A 4 bpp byte that yields two pixels gives two separate output items. The
// four-entry queue absorbs short bursts of such bytes, but a long run of
// them makes the input wait for the output. Palette colors come from the
// registered palette RAM read issued when an item enters the output stage.
// Before each palette entry is written, input waits until the queue holds
// no entries.
// ----------------------------------------------------------------------------
module bmp_to_rgba_decoder_unit import bmpd_pkg::*; #(
  parameter int MAX_DIM       = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
  output logic        m_axis_tlast,   // last_pixel
  output logic [2:0]  m_axis_tuser    // [2:0] status
);

  localparam int IW = $clog2(PALETTE_DEPTH);

  logic          push;
  entry_t        push_entry;
  logic          q_full;
  logic          q_empty;
  logic          pop;
  entry_t        head;
  logic          pal_we;
  logic [IW-1:0] pal_waddr;
  logic [23:0]   pal_wdata;
  logic          pal_re;
  logic [IW-1:0] pal_raddr;
  logic [23:0]   pal_rdata;

  // Byte parser.
  bmpd_front #(
    .MAX_DIM       (MAX_DIM),
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_data    (s_axis_tdata),
    .in_last    (s_axis_tlast),
    .push       (push),
    .push_entry (push_entry),
    .q_full     (q_full),
    .q_empty    (q_empty),
    .pal_we     (pal_we),
    .pal_waddr  (pal_waddr),
    .pal_wdata  (pal_wdata)
  );

  // Result queue.
  bmpd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .empty      (q_empty),
    .pop        (pop),
    .head       (head)
  );

  // Palette store.
  bmpd_ram #(
    .WIDTH (24),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pal_waddr),
    .wdata (pal_wdata),
    .re    (pal_re),
    .raddr (pal_raddr),
    .rdata (pal_rdata)
  );

  // Output stage.
  bmpd_back #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_empty    (q_empty),
    .pop        (pop),
    .pal_re     (pal_re),
    .pal_raddr  (pal_raddr),
    .pal_rdata  (pal_rdata),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata),
    .out_last   (m_axis_tlast),
    .out_status (m_axis_tuser)
  );

endmodule

### bench/bmp_rgba_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_rgba_checker
// Watches both streams of the BMP decoder, works out the pixels and error
// statuses that each accepted file byte should cause, and compares every
// output item with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module bmp_rgba_checker import bmpd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
  input  logic        m_axis_tlast,   // last_pixel
  input  logic [2:0]  m_axis_tuser,   // [2:0] status
  output int          fail_count,
  output int          pending_count
);

  localparam int MAX_DIM       = 4096;
  localparam int PALETTE_DEPTH = 256;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
    logic [2:0] status;
  } rgba_t;

  rgba_t expected_pixels[$];

  // Decoder state as seen by the file parser.
  logic [31:0] file_pos;
  logic [31:0] data_offset;
  logic [12:0] img_w;
  logic [12:0] img_h;
  logic [5:0]  bpp;
  logic [8:0]  pal_count;
  logic [12:0] col;
  logic [12:0] row;
  logic [23:0] pend;
  logic [1:0]  pix_byte;
  logic [1:0]  row_phase;
  phase_t      dec_phase;
  logic [23:0] palette [PALETTE_DEPTH];

  initial begin
    fail_count    = 0;
    pending_count = 0;
    for (int i = 0; i < PALETTE_DEPTH; i++) palette[i] = '0;
  end

  // Return to the state of a fresh file; the palette is kept.
  function automatic void rearm();
    file_pos    = '0;
    data_offset = '0;
    img_w       = '0;
    img_h       = '0;
    bpp         = '0;
    pal_count   = '0;
    col         = '0;
    row         = '0;
    pend        = '0;
    pix_byte    = '0;
    row_phase   = '0;
    dec_phase   = PH_HEADER;
  endfunction

  // Collects a little-endian header field; returns 1 on its final byte.
  function automatic logic take_field(input logic [31:0] pos, input logic [5:0] first,
                                      input int len, input logic [7:0] b,
                                      output logic [31:0] val);
    logic [31:0] k;
    logic [31:0] word;
    val = '0;
    if (pos < first || pos >= first + len) return 1'b0;
    k = pos - first;
    word = (k == 0) ? {24'b0, b} : ({8'b0, pend} | ({24'b0, b} << (8 * k)));
    if (k + 1 == len) begin
      val = word;
      return 1'b1;
    end
    pend = word[23:0];
    return 1'b0;
  endfunction

  // Palette lookup; indices beyond the palette count give black.
  function automatic rgba_t palette_pixel(input logic [7:0] idx);
    logic [23:0] c;
    c = (idx < pal_count) ? palette[idx] : 24'h0;
    return '{c[23:16], c[15:8], c[7:0], 8'hFF, 1'b0, ST_PIXEL};
  endfunction

  // Counts one pixel; marks the final pixel and returns 1 at a row end.
  function automatic logic step_column(inout rgba_t r);
    col++;
    if (col < img_w) return 1'b0;
    col = '0;
    row++;
    if (row >= img_h) begin
      r.last    = 1'b1;
      dec_phase = PH_DONE;
    end
    return 1'b1;
  endfunction

  // Works out the results of one accepted file byte.
  function automatic void predict_byte(input logic [7:0] b, input logic l);
    logic [31:0] pos;
    logic [31:0] v;
    logic [31:0] base;
    logic [31:0] rel;
    logic [2:0]  err;
    logic        row_end;
    int          n;
    int          top;
    rgba_t       res [2];
    pos = file_pos;
    v = '0;
    err = ST_PIXEL;
    row_end = 1'b0;
    n = 0;
    res[0] = '0;
    res[1] = '0;
    case (dec_phase)
      PH_HEADER: begin
        if (pos == 0 && b != "B") err = ST_SIG;
        if (pos == 1 && b != "M") err = ST_SIG;
        if (take_field(pos, POS_OFFSET, 4, b, v)) data_offset = v;
        if (take_field(pos, POS_WIDTH, 4, b, v)) begin
          if (v == 0 || v > MAX_DIM) err = ST_DIM;
          else img_w = v[12:0];
        end
        if (take_field(pos, POS_HEIGHT, 4, b, v)) begin
          if (v == 0 || v > MAX_DIM) err = ST_DIM;
          else img_h = v[12:0];
        end
        if (take_field(pos, POS_PLANES, 2, b, v) && v != 1) err = ST_PLANES;
        if (take_field(pos, POS_BPP, 2, b, v)) begin
          if (v != 4 && v != 8 && v != 24 && v != 32) err = ST_BPP;
          else bpp = v[5:0];
        end
        if (take_field(pos, POS_COMPR, 4, b, v) && v != 0 && (v != 3 || bpp != 32))
          err = ST_COMPRESS;
        if (take_field(pos, POS_PALCNT, 4, b, v)) begin
          if (v > PALETTE_DEPTH) begin
            err = ST_PALETTE;
          end else if (bpp <= 8 && (v == 0 || data_offset < HDR_LEN + 4 * v)) begin
            err = ST_PALETTE;
          end else begin
            pal_count = v[8:0];
            dec_phase = (data_offset <= HDR_LEN) ? PH_PIXELS : PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        // Palette entries sit just before the pixel data, four bytes each.
        if (bpp <= 8) begin
          base = data_offset - 4 * pal_count;
          if (pos >= base && pos < data_offset) begin
            rel = pos - base;
            if (rel[31:2] < PALETTE_DEPTH && rel[1:0] != 2'd3)
              palette[rel[9:2]][8 * rel[1:0] +: 8] = b;
          end
        end
        if ({32'b0, pos} + 64'd1 >= {32'b0, data_offset}) dec_phase = PH_PIXELS;
      end
      PH_PIXELS: begin
        if (bpp == 4) begin
          res[0] = palette_pixel({4'h0, b[7:4]});
          row_end = step_column(res[0]);
          n = 1;
          if (!row_end) begin
            res[1] = palette_pixel({4'h0, b[3:0]});
            row_end = step_column(res[1]);
            n = 2;
          end
        end else if (bpp == 8) begin
          res[0] = palette_pixel(b);
          row_end = step_column(res[0]);
          n = 1;
        end else begin
          top = (bpp == 32) ? 3 : 2;
          if (pix_byte >= top) begin
            if (top == 3) res[0] = '{pend[23:16], pend[15:8], pend[7:0], b, 1'b0, ST_PIXEL};
            else res[0] = '{b, pend[15:8], pend[7:0], 8'hFF, 1'b0, ST_PIXEL};
            pix_byte = '0;
            pend = '0;
            row_end = step_column(res[0]);
            n = 1;
          end else begin
            pend[8 * pix_byte +: 8] = b;
            pix_byte++;
          end
        end
        row_phase++;
        if (row_end && dec_phase == PH_PIXELS && row_phase != 0) dec_phase = PH_PAD;
      end
      PH_PAD: begin
        row_phase++;
        if (row_phase == 0) dec_phase = PH_PIXELS;
      end
      default: ;
    endcase

    if (err != ST_PIXEL) begin
      res[0] = '{8'h0, 8'h0, 8'h0, 8'h0, 1'b1, err};
      n = 1;
      dec_phase = PH_ERROR;
    end
    if (file_pos != 32'hFFFF_FFFF) file_pos++;

    // The final byte of a file ends any unfinished image as truncated.
    if (l) begin
      if (dec_phase != PH_DONE && dec_phase != PH_ERROR) begin
        res[0] = '{8'h0, 8'h0, 8'h0, 8'h0, 1'b1, ST_TRUNC};
        n = 1;
      end
      rearm();
    end
    for (int i = 0; i < n; i++) expected_pixels = {expected_pixels, res[i]};
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("[%0t] mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    rgba_t want;
    if (rst) begin
      rearm();
      expected_pixels.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_pixels.size() == 0) begin
          report("status of an unexpected item", int'(m_axis_tuser), -1);
        end else begin
          want = expected_pixels.pop_front();
          if (m_axis_tdata[7:0] != want.red)
            report("red", int'(m_axis_tdata[7:0]), int'(want.red));
          if (m_axis_tdata[15:8] != want.green)
            report("green", int'(m_axis_tdata[15:8]), int'(want.green));
          if (m_axis_tdata[23:16] != want.blue)
            report("blue", int'(m_axis_tdata[23:16]), int'(want.blue));
          if (m_axis_tdata[31:24] != want.alpha)
            report("alpha", int'(m_axis_tdata[31:24]), int'(want.alpha));
          if (m_axis_tlast !== want.last)
            report("last pixel", int'(m_axis_tlast), int'(want.last));
          if (m_axis_tuser !== want.status)
            report("status", int'(m_axis_tuser), int'(want.status));
        end
      end
    end
    pending_count = expected_pixels.size();
  end

endmodule

### bench/tb_bmp_to_rgba_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bmp_to_rgba_decoder_unit
// Feeds the BMP decoder with whole files: valid images of every pixel depth,
// each header error, truncated files, trailing bytes and plain noise, with
// random gaps and stalls on both streams. The checker does all comparisons.
// ----------------------------------------------------------------------------
module tb_bmp_to_rgba_decoder_unit;
  import bmpd_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int TOTAL_ITEMS = 1700;
  localparam int BUILD_CAP = 1500;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] data_byte
  logic        s_axis_tlast;   // last_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
  logic        m_axis_tlast;   // last_pixel
  logic [2:0]  m_axis_tuser;   // [2:0] status

  int          fail_count;
  int          pending_count;
  int          cycles;
  int          bytes_sent;
  logic        idle_on;
  logic        long_hold;
  logic [7:0]  file_bytes[$];

  bmp_to_rgba_decoder_unit DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser)
  );

  bmp_rgba_checker checker_i (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Run limit.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[bmp_to_rgba_decoder_unit] ERROR");
      $finish;
    end
  end

  // Pixel receiver: random stalls per item, with one long hold on request.
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end
      gap = idle_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(negedge clk); while (!m_axis_tvalid);
      @(posedge clk);
    end
  end

  // Offers one file byte and returns at the edge where it is taken.
  task automatic send_byte(input logic [7:0] d, input logic l);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tlast  <= l;
    do @(negedge clk); while (!s_axis_tready);
    @(posedge clk);
    bytes_sent++;
  endtask

  // Appends one byte to the file under construction.
  function automatic void add_byte(input logic [7:0] d);
    file_bytes = {file_bytes, d};
  endfunction

  function automatic void set_le(input logic [5:0] p, input int n, input logic [31:0] v);
    for (int i = 0; i < n; i++) file_bytes[p + i] = v[8 * i +: 8];
  endfunction

  // Lays out a file: header, palette area up to the offset, padded rows.
  task automatic build_file(input int depth, input int w, input int h, input int pc,
                            input int off, input int comp);
    int row_bytes;
    file_bytes.delete();
    for (int i = 0; i < 50; i++) add_byte(8'($urandom_range(0, 255)));
    file_bytes[0] = "B";
    file_bytes[1] = "M";
    set_le(POS_OFFSET, 4, off);
    set_le(POS_WIDTH, 4, w);
    set_le(POS_HEIGHT, 4, h);
    set_le(POS_PLANES, 2, 1);
    set_le(POS_BPP, 2, depth);
    set_le(POS_COMPR, 4, comp);
    set_le(POS_PALCNT, 4, pc);
    while (file_bytes.size() < off) add_byte(8'($urandom_range(0, 255)));
    row_bytes = (depth == 4) ? (w + 1) / 2 : w * depth / 8;
    row_bytes = (row_bytes + 3) / 4 * 4;
    for (int r = 0; r < h * row_bytes && file_bytes.size() < BUILD_CAP; r++)
      add_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_file();
    foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
  endtask

  // A well-formed file of random shape; palette depths get a fitting offset.
  task automatic random_image();
    int depth, w, h, pc, off, comp;
    case ($urandom_range(0, 3))
      0: depth = 4;
      1: depth = 8;
      2: depth = 24;
      default: depth = 32;
    endcase
    w = $urandom_range(1, 6);
    h = $urandom_range(1, 4);
    comp = (depth == 32 && $urandom_range(0, 1)) ? 3 : 0;
    if (depth <= 8) begin
      pc = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 256)
                                       : $urandom_range(1, depth == 4 ? 16 : 24);
      off = 50 + 4 * pc + $urandom_range(0, 3);
    end else begin
      pc = $urandom_range(0, 256);
      off = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 50) : 50 + $urandom_range(0, 6);
    end
    build_file(depth, w, h, pc, off, comp);
  endtask

  // Breaks one header field of the file in file_bytes.
  task automatic break_field(input int which);
    logic [31:0] v;
    case (which)
      0: file_bytes[0] = file_bytes[0] ^ 8'($urandom_range(1, 255));
      1: file_bytes[1] = file_bytes[1] ^ 8'($urandom_range(1, 255));
      2: set_le(POS_PLANES, 2, $urandom_range(0, 1) ? 0 : $urandom_range(2, 65535));
      3: begin
        v = $urandom_range(0, 65535);
        if (v == 4 || v == 8 || v == 24 || v == 32) v = 16;
        set_le(POS_BPP, 2, v);
      end
      4: begin
        v = $urandom;
        if (v == 0 || v == 3) v = 1;
        set_le(POS_COMPR, 4, v);
      end
      5, 6: begin
        case ($urandom_range(0, 2))
          0: v = 0;
          1: v = 32'h8000_0000 | $urandom;
          default: v = 4097 + $urandom_range(0, 5000);
        endcase
        set_le(which == 5 ? POS_WIDTH : POS_HEIGHT, 4, v);
      end
      7: set_le(POS_PALCNT, 4, $urandom_range(0, 1) ? $urandom_range(257, 1000) : $urandom);
      8: set_le(POS_PALCNT, 4, 0);
      default: set_le(POS_OFFSET, 4, $urandom_range(0, 60));
    endcase
  endtask

  // Stops the sender until every outstanding result has arrived.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin
    int kind;
    int cut;
    int n;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    idle_on       = 1'b1;
    long_hold     = 1'b0;
    bytes_sent    = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every depth, and 32 bpp with bitfields compression.
    build_file(4, 3, 2, 16, 50 + 64, 0);
    send_file();
    build_file(8, 2, 2, 32, 50 + 128, 0);
    send_file();
    build_file(24, 3, 2, 0, 54, 0);
    send_file();
    build_file(32, 2, 2, 0, 50, 3);
    send_file();
    // Indices beyond the palette and a small pixel offset.
    build_file(4, 5, 1, 2, 58, 0);
    send_file();
    build_file(24, 2, 1, 7, 14, 0);
    send_file();
    // Largest dimensions, truncated early.
    build_file(8, 4096, 4096, 1, 54, 0);
    file_bytes = file_bytes[0:69];
    send_file();
    // Each header error once, and garbage after a complete image.
    for (int f = 0; f < 10; f++) begin
      build_file(8, 2, 1, 3, 62, 0);
      break_field(f);
      file_bytes = file_bytes[0:49];
      send_file();
    end
    build_file(24, 1, 1, 0, 50, 0);
    repeat (5) add_byte(8'hFF);
    send_file();

    // The receiver holds off while a long image keeps coming.
    long_hold = 1'b1;
    build_file(4, 6, 4, 4, 70, 0);
    send_file();
    drain();

    // Random files until enough bytes have been offered in total.
    n = 0;
    while (bytes_sent < TOTAL_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 11);
      random_image();
      if (kind == 8) break_field($urandom_range(0, 9));
      if (kind == 9) begin
        cut = $urandom_range(1, file_bytes.size() - 1);
        file_bytes = file_bytes[0:cut - 1];
      end
      if (kind == 10) repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
      if (kind == 11) begin
        file_bytes.delete();
        repeat ($urandom_range(1, 60)) add_byte(8'($urandom_range(0, 255)));
      end
      send_file();
      n++;
      if (n % 7 == 0) drain();
    end
    s_axis_tvalid <= 1'b0;

    // Let the last results arrive.
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("[bmp_to_rgba_decoder_unit] OK");
    end else begin
      $display("[bmp_to_rgba_decoder_unit] ERROR");
    end
    $finish;
  end

endmodule

### bmp_to_rgba_decoder_unit.f
sv/bmpd_pkg.sv
sv/bmpd_ram.sv
sv/bmpd_queue.sv
sv/bmpd_front.sv
sv/bmpd_back.sv
sv/bmp_to_rgba_decoder_unit.sv
bench/bmp_rgba_checker.sv
bench/tb_bmp_to_rgba_decoder_unit.sv
